@@ src/skrq_pkg.sv @@
// Shared types and status codes for the sorted key range query block.
`default_nettype none
package skrq_pkg;
  localparam int KEY_BITS   = 32;
  localparam int INDEX_BITS = 16;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_HIT      = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [KEY_BITS-1:0] key_value;
    logic signed [KEY_BITS-1:0] key_upper;
    logic [INDEX_BITS-1:0]      entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [INDEX_BITS-1:0] hit_index;
    logic                  last;
  } out_word_t;
endpackage
`default_nettype wire

@@ src/skrq_ram.sv @@
// Single-port-write, registered-read memory used for the table and hit stores.
`default_nettype none
module skrq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/sorted_key_range_index_query.sv @@
// Top level: sorted (key, index) table with insert and inclusive range query.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_valid / in_ready    | skrq_pkg::in_word_t
//  out_    | out | out_valid / out_ready  | skrq_pkg::out_word_t
//
// Insert: walk down from the top entry, a read then a shift write per shifted
// entry, until the new pair is dropped into its slot.
// Full table: no walk; the FULL status goes straight to the response state.
// Query: a read and a compare per scanned entry, plus a read and a shift write
// per hit entry moved by the ordering walk, then a read per hit word output.
// Reset clears only the entry count and control; one item at a time, and the
// output register holds its word until out_ready.
`default_nettype none
module sorted_key_range_index_query #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skrq_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skrq_pkg::out_word_t      out_data
);
  localparam int KEY_BITS   = skrq_pkg::KEY_BITS;
  localparam int INDEX_BITS = skrq_pkg::INDEX_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IRD    = 4'd1;
  localparam logic [3:0] S_ICMP   = 4'd2;
  localparam logic [3:0] S_QRD    = 4'd3;
  localparam logic [3:0] S_QCMP   = 4'd4;
  localparam logic [3:0] S_HRD    = 4'd5;
  localparam logic [3:0] S_HCMP   = 4'd6;
  localparam logic [3:0] S_ORD    = 4'd7;
  localparam logic [3:0] S_OWAIT  = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;     // walk position (slot being filled)
  logic [CW-1:0]         scan_r, scan_nxt;   // query scan index
  logic [CW-1:0]         hits_r, hits_nxt;
  logic [CW-1:0]         hpos_r, hpos_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;     // offset-binary insert key / low
  logic [KEY_BITS-1:0]   hi_r, hi_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;     // insert index / pending hit
  logic [1:0]            rstat_r, rstat_nxt; // status of the single-word reply
  logic                  ovalid_r, ovalid_nxt;
  skrq_pkg::out_word_t   odata_r, odata_nxt;

  // table memories
  logic                  t_we;
  logic [AW-1:0]         t_waddr, t_raddr;
  logic [KEY_BITS-1:0]   tk_wdata, tk_rdata;
  logic [INDEX_BITS-1:0] ti_wdata, ti_rdata;
  // hit memory
  logic                  h_we;
  logic [AW-1:0]         h_waddr, h_raddr;
  logic [INDEX_BITS-1:0] h_wdata, h_rdata;

  skrq_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(KEY_BITS)) u_key (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(tk_wdata), .raddr(t_raddr), .rdata(tk_rdata));
  skrq_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(INDEX_BITS)) u_idx (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(ti_wdata), .raddr(t_raddr), .rdata(ti_rdata));
  skrq_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(INDEX_BITS)) u_hit (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));

  logic [KEY_BITS-1:0] sign_bit;
  assign sign_bit = {1'b1, {(KEY_BITS-1){1'b0}}};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  logic out_free;
  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    scan_nxt   = scan_r;
    hits_nxt   = hits_r;
    hpos_nxt   = hpos_r;
    key_nxt    = key_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    rstat_nxt  = rstat_r;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt  = odata_r;
    t_we       = 1'b0;
    t_waddr    = pos_r[AW-1:0];
    tk_wdata   = key_r;
    ti_wdata   = idx_r;
    t_raddr    = scan_r[AW-1:0];
    h_we       = 1'b0;
    h_waddr    = hpos_r[AW-1:0];
    h_wdata    = idx_r;
    h_raddr    = hpos_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.key_value[KEY_BITS-1:0] ^ sign_bit;
          hi_nxt  = in_data.key_upper[KEY_BITS-1:0] ^ sign_bit;
          idx_nxt = in_data.entry_index[INDEX_BITS-1:0];
          pos_nxt = count_r;
          scan_nxt = '0;
          hits_nxt = '0;
          if (in_data.cmd == skrq_pkg::CMD_INSERT) begin
            if (count_r == CW'(TABLE_DEPTH)) begin
              rstat_nxt = skrq_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_IRD;
            end
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_IRD: begin
        if (pos_r == '0) begin
          t_we = 1'b1;
          count_nxt = count_r + 1'b1;
          rstat_nxt = skrq_pkg::ST_INSERTED;
          state_nxt = S_RESP;
        end else begin
          t_raddr = AW'(pos_r - 1'b1);
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        // shift the larger entry up one slot, or drop the new pair in here
        t_we = 1'b1;
        if (tk_rdata > key_r) begin
          tk_wdata = tk_rdata;
          ti_wdata = ti_rdata;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_IRD;
        end else begin
          count_nxt = count_r + 1'b1;
          rstat_nxt = skrq_pkg::ST_INSERTED;
          state_nxt = S_RESP;
        end
      end
      S_QRD: begin
        if (scan_r == count_r) begin
          if (hits_r == '0) begin
            rstat_nxt = skrq_pkg::ST_EMPTY;
            state_nxt = S_RESP;
          end else begin
            hpos_nxt = '0;
            state_nxt = S_ORD;
          end
        end else begin
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        scan_nxt = scan_r + 1'b1;
        if (tk_rdata >= key_r && tk_rdata <= hi_r) begin
          idx_nxt = ti_rdata;
          hpos_nxt = hits_r;
          hits_nxt = hits_r + 1'b1;
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_HRD: begin
        if (hpos_r == '0) begin
          h_we = 1'b1;
          state_nxt = S_QRD;
        end else begin
          h_raddr = AW'(hpos_r - 1'b1);
          state_nxt = S_HCMP;
        end
      end
      S_HCMP: begin
        h_we = 1'b1;
        if (h_rdata > idx_r) begin
          h_wdata = h_rdata;
          hpos_nxt = hpos_r - 1'b1;
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_ORD: begin
        // read issued for hpos_r; data valid next cycle
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt = '{status: skrq_pkg::ST_HIT, hit_index: h_rdata,
                        last: (hpos_r + 1'b1 == hits_r)};
          if (hpos_r + 1'b1 == hits_r) begin
            state_nxt = S_IDLE;
          end else begin
            hpos_nxt = hpos_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt = '{status: rstat_r, hit_index: '0, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      hits_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      hits_r   <= hits_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pos_r   <= pos_nxt;
    scan_r  <= scan_nxt;
    hpos_r  <= hpos_nxt;
    key_r   <= key_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    rstat_r <= rstat_nxt;
    odata_r <= odata_nxt;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count moved by other than one");
  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= count_r) else $error("more hits than entries");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted two words back to back");
`endif
endmodule
`default_nettype wire

@@ dv/skrq_checker.sv @@
// Checker for the sorted key range query block: predicts results and compares them.
module skrq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  skrq_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  skrq_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic signed [31:0]  tbl_key [DEPTH];
  logic [15:0]         tbl_idx [DEPTH];
  int                  tbl_count;
  skrq_pkg::out_word_t expected_words [$];

  assign pending = expected_words.size();

  function automatic skrq_pkg::out_word_t make_word(logic [1:0] st, logic [15:0] idx,
                                                    logic lst);
    skrq_pkg::out_word_t w;
    w.status = st;
    w.hit_index = idx;
    w.last = lst;
    return w;
  endfunction

  task automatic predict_item(skrq_pkg::in_word_t w);
    int pos;
    int n;
    logic [15:0] hits [$];
    if (w.cmd == skrq_pkg::CMD_INSERT) begin
      if (tbl_count >= DEPTH) begin
        expected_words = {expected_words, make_word(skrq_pkg::ST_FULL, 16'd0, 1'b1)};
      end else begin
        // place after any equal keys
        pos = tbl_count;
        while (pos > 0 && tbl_key[pos-1] > w.key_value) begin
          tbl_key[pos] = tbl_key[pos-1];
          tbl_idx[pos] = tbl_idx[pos-1];
          pos--;
        end
        tbl_key[pos] = w.key_value;
        tbl_idx[pos] = w.entry_index;
        tbl_count++;
        expected_words = {expected_words, make_word(skrq_pkg::ST_INSERTED, 16'd0, 1'b1)};
      end
    end else begin
      for (int i = 0; i < tbl_count; i++)
        if (tbl_key[i] >= w.key_value && tbl_key[i] <= w.key_upper) hits = {hits, tbl_idx[i]};
      hits.sort();
      n = hits.size();
      if (n == 0)
        expected_words = {expected_words, make_word(skrq_pkg::ST_EMPTY, 16'd0, 1'b1)};
      for (int i = 0; i < n; i++)
        expected_words = {expected_words, make_word(skrq_pkg::ST_HIT, hits[i], i == n - 1)};
    end
  endtask

  always @(posedge clk) begin
    skrq_pkg::out_word_t want;
    if (!rst_n) begin
      tbl_count = 0;
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word status=%0d idx=%0d last=%0b", $time,
                   out_data.status, out_data.hit_index, out_data.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_data) begin
            $display("%0t: expected status=%0d idx=%0d last=%0b, got status=%0d idx=%0d last=%0b",
                     $time, want.status, want.hit_index, want.last,
                     out_data.status, out_data.hit_index, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
  end
endmodule

@@ dv/sorted_key_range_index_query_tb.sv @@
// Testbench top for the sorted key range query block: stimulus and verdict.
module sorted_key_range_index_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  skrq_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  skrq_pkg::out_word_t out_data;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  quiet_cycles;
  int                  n_inserted;
  logic signed [31:0]  used_keys [$];

  sorted_key_range_index_query u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  skrq_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // valid stays high after acceptance until the next word or an idle cycle drops it
  task automatic send_word(skrq_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_insert(logic signed [31:0] k, logic [15:0] idx);
    skrq_pkg::in_word_t w;
    w.cmd = skrq_pkg::CMD_INSERT;
    w.key_value = k;
    w.key_upper = $urandom;
    w.entry_index = idx;
    used_keys = {used_keys, k};
    n_inserted++;
    send_word(w);
  endtask

  task automatic send_query(logic signed [31:0] lo, logic signed [31:0] hi);
    skrq_pkg::in_word_t w;
    w.cmd = skrq_pkg::CMD_QUERY;
    w.key_value = lo;
    w.key_upper = hi;
    w.entry_index = $urandom;
    send_word(w);
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 3 && used_keys.size() > 0) return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 6) return $signed(32'($urandom_range(40))) - 32'sd20;
    return $urandom;
  endfunction

  task automatic random_phase(int items, int idle_pct, int stall);
    logic signed [31:0] a;
    logic signed [31:0] b;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 55) begin
        send_insert(pick_key(), $urandom);
      end else begin
        a = pick_key();
        b = pick_key();
        if ($urandom_range(9) < 8 && a > b) send_query(b, a);
        else send_query(a, b);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    n_inserted = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, inverted range
    send_query(32'sh8000_0000, 32'sh7fff_ffff);
    send_insert(32'sh7fff_ffff, 16'hffff);
    send_insert(32'sh8000_0000, 16'h0000);
    send_insert(32'sd5, 16'd9);
    send_insert(32'sd5, 16'd3);
    send_insert(32'sd5, 16'd3);
    send_insert(-32'sd1, 16'h5555);
    send_insert(32'sd0, 16'haaaa);
    send_query(32'sh8000_0000, 32'sh7fff_ffff);
    send_query(32'sd5, 32'sd5);
    send_query(32'sd6, 32'sd4);
    send_query(32'sd100, 32'sd200);
    send_query(-32'sd1, 32'sd0);
    send_query(32'sh7fff_ffff, 32'sh7fff_ffff);

    random_phase(60, 0, 0);
    random_phase(60, 55, 0);
    random_phase(50, 0, 55);
    random_phase(40, 9, 9);

    // fill to full, then drop and query everything
    send_idle_pct = 0;
    stall_pct = 0;
    while (n_inserted < 66) send_insert(pick_key(), $urandom);
    send_query(32'sh8000_0000, 32'sh7fff_ffff);
    send_query(32'sh8000_0000, 32'sh8000_0000);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
